// ===== hdl/ptc_pkg.sv =====
`default_nettype none

package ptc_pkg;

  localparam int ID_W        = 12;
  localparam int DIST_W      = 16;
  localparam int CFG_IDX_W   = 2;
  localparam int RESULT_LIMIT = 50;
  localparam int ROW_W       = 6;
  localparam logic [15:0] THRESHOLD_RESET = 16'd180;

  localparam logic [CFG_IDX_W-1:0] CFG_ADD_THR   = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_MERGE_THR = 2'd1;

  localparam logic [2:0] ACT_IGNORED  = 3'd0;
  localparam logic [2:0] ACT_SECOND   = 3'd1;
  localparam logic [2:0] ACT_FIRST    = 3'd2;
  localparam logic [2:0] ACT_MERGED   = 3'd3;
  localparam logic [2:0] ACT_OPENED   = 3'd4;
  localparam logic [2:0] ACT_OVERFLOW = 3'd5;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SEARCH,
    ST_OPEN2,
    ST_MERGE,
    ST_REPORT,
    ST_READ
  } state_t;

  typedef struct packed {
    logic            ins_en;
    logic            clr;
    logic [ID_W-1:0] ins_id;
    logic            ins_flag;
  } cell_cmd_t;

  typedef struct packed {
    logic            first_a;
    logic            first_b;
    logic [ID_W-1:0] rd_id;
    logic            rd_flag;
  } cell_stat_t;

endpackage

`default_nettype wire

// ===== hdl/ptc_cell.sv =====
`default_nettype none

module ptc_cell #(
  parameter int CAP = 8,
  localparam int CW = $clog2(CAP)
) (
  input  wire logic                     clk,
  input  wire logic                     rst_n,
  input  wire ptc_pkg::cell_cmd_t       cmd,
  input  wire logic [CW-1:0]            rd_idx,
  input  wire logic [ptc_pkg::ID_W-1:0] key_a,
  input  wire logic [ptc_pkg::ID_W-1:0] key_b,
  input  wire logic                     found_a_in,
  input  wire logic                     found_b_in,
  output logic                          found_a_out,
  output logic                          found_b_out,
  output logic [CW-1:0]                 count,
  output ptc_pkg::cell_stat_t           stat
);
  import ptc_pkg::*;

  logic [ID_W-1:0] ids_r   [CAP];
  logic            flags_r [CAP];
  logic [ID_W-1:0] ids_nxt [CAP];
  logic            flags_nxt [CAP];
  logic [CW-1:0]   cnt_r, cnt_nxt;
  logic [CAP-1:0]  keep;
  logic            hit_a, hit_b;

  always_comb begin
    hit_a = 1'b0;
    hit_b = 1'b0;
    for (int k = 0; k < CAP; k++) begin
      if (CW'(k) < cnt_r && ids_r[k] == key_a) hit_a = 1'b1;
      if (CW'(k) < cnt_r && ids_r[k] == key_b) hit_b = 1'b1;
      keep[k] = (CW'(k) < cnt_r) && (ids_r[k] <= cmd.ins_id);
    end
  end

  assign found_a_out   = found_a_in | hit_a;
  assign found_b_out   = found_b_in | hit_b;
  assign stat.first_a  = hit_a & ~found_a_in;
  assign stat.first_b  = hit_b & ~found_b_in;
  assign stat.rd_id    = ids_r[rd_idx];
  assign stat.rd_flag  = flags_r[rd_idx];
  assign count         = cnt_r;

  always_comb begin
    for (int k = 0; k < CAP; k++) begin
      ids_nxt[k]   = ids_r[k];
      flags_nxt[k] = flags_r[k];
      if (!keep[k]) begin
        if (k == 0 || keep[(k == 0) ? 0 : k-1]) begin
          ids_nxt[k]   = cmd.ins_id;
          flags_nxt[k] = cmd.ins_flag;
        end else begin
          ids_nxt[k]   = ids_r[(k == 0) ? 0 : k-1];
          flags_nxt[k] = flags_r[(k == 0) ? 0 : k-1];
        end
      end
    end
    cnt_nxt = cnt_r;
    if (cmd.clr) cnt_nxt = '0;
    else if (cmd.ins_en) cnt_nxt = cnt_r + 1'b1;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= '0;
    end else begin
      cnt_r <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.ins_en) begin
      ids_r   <= ids_nxt;
      flags_r <= flags_nxt;
    end
  end

endmodule

`default_nettype wire

// ===== hdl/pair_threshold_clusterer.sv =====
// Single-linkage clusterer for a stream of candidate item pairs.
// Input channel (in_*): one beat per pair with both ids, their flags, the
// distance and last_pair. Configuration channel (cfg_*): index 0 writes the
// add threshold, index 1 the merge threshold; it is always ready. The user
// must write it only while the block is idle; the block does not enforce it.
// Output channel (out_*): one report beat per pair, and on the last pair
// one beat per stored member, at most 49, slot by slot in ascending id
// order, the last beat marked with end_of_run.
// Each cluster slot is a cell that compares its members against both ids
// in parallel and keeps them sorted as they are inserted. A pair is first
// searched and then reported; opening a cluster adds a state inserting the
// second id, and a merge moves the members of the higher slot to the lower
// slot one by one. Readout skips empty slots. Only one pair is in work at a time.
// A stalled receiver holds the block in its output states; the next pair is
// taken once the last beat of the current one is in the output register.
// Reset empties all slots and sets both thresholds to 180; after a last
// pair the slots, the live count and the overflow flag are cleared again.
`default_nettype none

module pair_threshold_clusterer #(
  parameter int CLUSTER_SLOTS    = 8,
  parameter int CLUSTER_CAPACITY = 8
) (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire logic                          cfg_valid,
  output logic                               cfg_ready,
  input  wire logic [ptc_pkg::CFG_IDX_W-1:0] cfg_index,
  input  wire logic [15:0]                   cfg_data,
  input  wire logic                          in_valid,
  output logic                               in_ready,
  input  wire logic [11:0]                   in_head_item,
  input  wire logic [11:0]                   in_second_item,
  input  wire logic [15:0]                   in_pair_distance,
  input  wire logic                          in_first_flag,
  input  wire logic                          in_second_flag,
  input  wire logic                          in_last_pair,
  output logic                               out_valid,
  input  wire logic                          out_ready,
  output logic                               out_result_type,
  output logic [2:0]                         out_action,
  output logic [2:0]                         out_cluster_slot,
  output logic [11:0]                        out_member_item,
  output logic                               out_member_flag,
  output logic [2:0]                         out_live_clusters,
  output logic                               out_overflow,
  output logic                               out_end_of_run
);
  import ptc_pkg::*;

  localparam int SW = $clog2(CLUSTER_SLOTS);
  localparam int CW = $clog2(CLUSTER_CAPACITY);

  state_t state_r, state_nxt;
  logic [15:0] add_thr_r, merge_thr_r;
  logic [ID_W-1:0] a_r, b_r;
  logic [DIST_W-1:0] d_r;
  logic fa_r, fb_r, last_r;
  logic [2:0] act_r, act_nxt;
  logic [SW-1:0] slot_r, slot_nxt, lo_r, lo_nxt, sel_r, sel_nxt;
  logic [SW-1:0] used_r, used_nxt, live_r, live_nxt;
  logic [CW-1:0] k_r, k_nxt;
  logic ovf_r, ovf_nxt;
  logic [ROW_W-1:0] rows_r, rows_nxt;

  logic ins_go, clr_all, clr_go;
  logic [SW-1:0] ins_tgt;
  logic [ID_W-1:0] ins_id;
  logic ins_flag;

  cell_cmd_t  cmd  [CLUSTER_SLOTS];
  cell_stat_t stat [CLUSTER_SLOTS];
  logic [CW-1:0] cnt [CLUSTER_SLOTS];
  logic [CLUSTER_SLOTS:0] chain_a, chain_b;

  logic out_valid_r, out_load, out_free;
  logic out_type_nxt, out_flag_nxt, out_end_nxt;
  logic [2:0] out_act_nxt;
  logic [SW-1:0] out_slot_nxt;
  logic [ID_W-1:0] out_item_nxt;
  logic out_type_r, out_flag_r, out_end_r, out_ovf_r;
  logic [2:0] out_act_r;
  logic [SW-1:0] out_slot_r, out_live_r;
  logic [ID_W-1:0] out_item_r;

  assign chain_a[0] = 1'b0;
  assign chain_b[0] = 1'b0;

  for (genvar i = 0; i < CLUSTER_SLOTS; i++) begin : g_cell
    always_comb begin
      cmd[i].ins_en   = ins_go && (ins_tgt == SW'(i));
      cmd[i].clr      = clr_all || (clr_go && sel_r == SW'(i));
      cmd[i].ins_id   = ins_id;
      cmd[i].ins_flag = ins_flag;
    end
    ptc_cell #(.CAP(CLUSTER_CAPACITY)) u_cell (
      .clk        (clk),
      .rst_n      (rst_n),
      .cmd        (cmd[i]),
      .rd_idx     (k_r),
      .key_a      (a_r),
      .key_b      (b_r),
      .found_a_in (chain_a[i]),
      .found_b_in (chain_b[i]),
      .found_a_out(chain_a[i+1]),
      .found_b_out(chain_b[i+1]),
      .count      (cnt[i]),
      .stat       (stat[i])
    );
  end

  logic [SW-1:0] si, sj, s_lo, s_hi;
  logic fnd_a, fnd_b, any_nz, any_above, fit_add, fit_merge;
  logic [CW:0] merge_sum;

  always_comb begin
    si = '0;
    sj = '0;
    any_nz = 1'b0;
    any_above = 1'b0;
    for (int i = 0; i < CLUSTER_SLOTS; i++) begin
      if (stat[i].first_a) si = SW'(i);
      if (stat[i].first_b) sj = SW'(i);
      if (cnt[i] != '0) any_nz = 1'b1;
      if (cnt[i] != '0 && i > int'(sel_r)) any_above = 1'b1;
    end
    fnd_a     = chain_a[CLUSTER_SLOTS];
    fnd_b     = chain_b[CLUSTER_SLOTS];
    s_lo      = (si < sj) ? si : sj;
    s_hi      = (si < sj) ? sj : si;
    merge_sum = {1'b0, cnt[s_lo]} + {1'b0, cnt[s_hi]};
    fit_add   = d_r <= add_thr_r;
    fit_merge = d_r <= merge_thr_r;
  end

  assign out_free  = !out_valid_r || out_ready;
  assign in_ready  = (state_r == ST_IDLE);
  assign cfg_ready = 1'b1;

  always_comb begin
    state_nxt = state_r;
    act_nxt   = act_r;
    slot_nxt  = slot_r;
    lo_nxt    = lo_r;
    sel_nxt   = sel_r;
    used_nxt  = used_r;
    live_nxt  = live_r;
    k_nxt     = k_r;
    ovf_nxt   = ovf_r;
    rows_nxt  = rows_r;
    ins_go    = 1'b0;
    ins_tgt   = '0;
    ins_id    = a_r;
    ins_flag  = fa_r;
    clr_all   = 1'b0;
    clr_go    = 1'b0;
    out_load     = 1'b0;
    out_type_nxt = 1'b0;
    out_act_nxt  = act_r;
    out_slot_nxt = slot_r;
    out_item_nxt = '0;
    out_flag_nxt = 1'b0;
    out_end_nxt  = 1'b0;
    case (state_r)
      ST_IDLE: begin
        if (in_valid) state_nxt = ST_SEARCH;
      end
      ST_SEARCH: begin
        act_nxt   = ACT_IGNORED;
        slot_nxt  = '0;
        state_nxt = ST_REPORT;
        if (fnd_a && !fnd_b && fit_add) begin
          slot_nxt = si;
          if (cnt[si] >= CW'(CLUSTER_CAPACITY - 1)) begin
            act_nxt = ACT_OVERFLOW;
            ovf_nxt = 1'b1;
          end else begin
            ins_go   = 1'b1;
            ins_tgt  = si;
            ins_id   = b_r;
            ins_flag = fb_r;
            act_nxt  = ACT_SECOND;
          end
        end else if (fnd_b && !fnd_a && fit_add) begin
          slot_nxt = sj;
          if (cnt[sj] >= CW'(CLUSTER_CAPACITY - 1)) begin
            act_nxt = ACT_OVERFLOW;
            ovf_nxt = 1'b1;
          end else begin
            ins_go  = 1'b1;
            ins_tgt = sj;
            act_nxt = ACT_FIRST;
          end
        end else if (fnd_a && fnd_b && si != sj && fit_merge) begin
          slot_nxt = s_lo;
          if (merge_sum > (CW+1)'(CLUSTER_CAPACITY - 1)) begin
            act_nxt = ACT_OVERFLOW;
            ovf_nxt = 1'b1;
          end else begin
            act_nxt   = ACT_MERGED;
            lo_nxt    = s_lo;
            sel_nxt   = s_hi;
            k_nxt     = '0;
            state_nxt = ST_MERGE;
          end
        end else if (!fnd_a && !fnd_b && fit_add) begin
          if (used_r >= SW'(CLUSTER_SLOTS - 1)) begin
            act_nxt = ACT_OVERFLOW;
            ovf_nxt = 1'b1;
          end else begin
            slot_nxt  = used_r;
            ins_go    = 1'b1;
            ins_tgt   = used_r;
            used_nxt  = used_r + 1'b1;
            live_nxt  = live_r + 1'b1;
            act_nxt   = ACT_OPENED;
            state_nxt = ST_OPEN2;
          end
        end
      end
      ST_OPEN2: begin
        ins_go    = 1'b1;
        ins_tgt   = slot_r;
        ins_id    = b_r;
        ins_flag  = fb_r;
        state_nxt = ST_REPORT;
      end
      ST_MERGE: begin
        ins_go   = 1'b1;
        ins_tgt  = lo_r;
        ins_id   = stat[sel_r].rd_id;
        ins_flag = stat[sel_r].rd_flag;
        if (k_r == cnt[sel_r] - 1'b1) begin
          clr_go    = 1'b1;
          if (live_r != '0) live_nxt = live_r - 1'b1;
          state_nxt = ST_REPORT;
        end else begin
          k_nxt = k_r + 1'b1;
        end
      end
      ST_REPORT: begin
        if (out_free) begin
          out_load    = 1'b1;
          out_end_nxt = last_r && !any_nz;
          sel_nxt     = '0;
          k_nxt       = '0;
          rows_nxt    = '0;
          if (!last_r) begin
            state_nxt = ST_IDLE;
          end else if (any_nz) begin
            state_nxt = ST_READ;
          end else begin
            clr_all   = 1'b1;
            state_nxt = ST_IDLE;
          end
        end
      end
      ST_READ: begin
        if (k_r >= cnt[sel_r]) begin
          sel_nxt = sel_r + 1'b1;
          k_nxt   = '0;
        end else if (out_free) begin
          out_load     = 1'b1;
          out_type_nxt = 1'b1;
          out_act_nxt  = ACT_IGNORED;
          out_slot_nxt = sel_r;
          out_item_nxt = stat[sel_r].rd_id;
          out_flag_nxt = stat[sel_r].rd_flag;
          out_end_nxt  = !((k_r + 1'b1 < cnt[sel_r]) || any_above) ||
                         (rows_r == ROW_W'(RESULT_LIMIT - 2));
          rows_nxt     = rows_r + 1'b1;
          if (out_end_nxt) begin
            clr_all   = 1'b1;
            state_nxt = ST_IDLE;
          end else if (k_r + 1'b1 == cnt[sel_r]) begin
            sel_nxt = sel_r + 1'b1;
            k_nxt   = '0;
          end else begin
            k_nxt = k_r + 1'b1;
          end
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
    if (clr_all) begin
      used_nxt = '0;
      live_nxt = '0;
      ovf_nxt  = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      add_thr_r   <= THRESHOLD_RESET;
      merge_thr_r <= THRESHOLD_RESET;
      used_r      <= '0;
      live_r      <= '0;
      ovf_r       <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      used_r  <= used_nxt;
      live_r  <= live_nxt;
      ovf_r   <= ovf_nxt;
      if (cfg_valid && cfg_index == CFG_ADD_THR) add_thr_r <= cfg_data;
      if (cfg_valid && cfg_index == CFG_MERGE_THR) merge_thr_r <= cfg_data;
      if (out_load) out_valid_r <= 1'b1;
      else if (out_ready) out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    act_r  <= act_nxt;
    slot_r <= slot_nxt;
    lo_r   <= lo_nxt;
    sel_r  <= sel_nxt;
    k_r    <= k_nxt;
    rows_r <= rows_nxt;
    if (in_valid && in_ready) begin
      a_r    <= in_head_item;
      b_r    <= in_second_item;
      d_r    <= in_pair_distance;
      fa_r   <= in_first_flag;
      fb_r   <= in_second_flag;
      last_r <= in_last_pair;
    end
    if (out_load) begin
      out_type_r <= out_type_nxt;
      out_act_r  <= out_act_nxt;
      out_slot_r <= out_slot_nxt;
      out_item_r <= out_item_nxt;
      out_flag_r <= out_flag_nxt;
      out_live_r <= live_r;
      out_ovf_r  <= ovf_r;
      out_end_r  <= out_end_nxt;
    end
  end

  assign out_valid         = out_valid_r;
  assign out_result_type   = out_type_r;
  assign out_action        = out_act_r;
  assign out_cluster_slot  = 3'(out_slot_r);
  assign out_member_item   = out_item_r;
  assign out_member_flag   = out_flag_r;
  assign out_live_clusters = 3'(out_live_r);
  assign out_overflow      = out_ovf_r;
  assign out_end_of_run    = out_end_r;

endmodule

`default_nettype wire

// ===== hdl/ptc_checker.sv =====
`default_nettype none

module ptc_checker (
  input wire logic        clk,
  input wire logic        rst_n,
  input wire logic        in_valid,
  input wire logic        in_ready,
  input wire logic        out_valid,
  input wire logic        out_ready,
  input wire logic        out_result_type,
  input wire logic [2:0]  out_action,
  input wire logic [11:0] out_member_item,
  input wire logic        out_member_flag,
  input wire logic        out_end_of_run
);
  import ptc_pkg::*;

  a_stall_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_member_item) &&
    $stable(out_action) && $stable(out_end_of_run))
    else $error("output beat changed while stalled");

  a_one_pair: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready)
    else $error("second pair taken while one is in work");

  a_read_action: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_result_type |-> out_action == ACT_IGNORED)
    else $error("readout beat carries an action");

  a_report_empty: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_result_type |-> out_member_item == '0 && !out_member_flag &&
    (out_action == ACT_IGNORED || out_action == ACT_SECOND || out_action == ACT_FIRST ||
     out_action == ACT_MERGED || out_action == ACT_OPENED || out_action == ACT_OVERFLOW))
    else $error("report beat malformed");

endmodule

bind pair_threshold_clusterer ptc_checker u_ptc_checker (
  .clk            (clk),
  .rst_n          (rst_n),
  .in_valid       (in_valid),
  .in_ready       (in_ready),
  .out_valid      (out_valid),
  .out_ready      (out_ready),
  .out_result_type(out_result_type),
  .out_action     (out_action),
  .out_member_item(out_member_item),
  .out_member_flag(out_member_flag),
  .out_end_of_run (out_end_of_run)
);

`default_nettype wire
